FILE: rtl/core/irqrr_pkg.sv
// ----------------------------------------------------------------------------
// irqrr_pkg
// Shared types, register codes and a helper function for the round-robin
// interrupt distributor.
// ----------------------------------------------------------------------------
package irqrr_pkg;

   localparam int MaxLines = 16;
   localparam int LineW    = 4;
   localparam int CpuW     = 4;
   localparam int TargetW  = 2;
   localparam int PtrW     = 3;

   localparam logic [PtrW-1:0] NoCpu = 3'd7;

   localparam logic [1:0] RegServiced = 2'd0;
   localparam logic [1:0] RegLocal    = 2'd1;
   localparam logic [1:0] RegActive   = 2'd2;
   localparam logic [1:0] RegAffinity = 2'd3;

   localparam logic [15:0] ServicedReset = 16'hD1FB;
   localparam logic [15:0] LocalReset    = 16'h1187;
   localparam logic [3:0]  ActiveReset   = 4'hF;
   localparam logic [63:0] AffinityReset = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic               hit;
      logic [LineW-1:0]   line;
      logic [TargetW-1:0] target;
      logic               last;
   } pick_type;

   function automatic logic [TargetW-1:0] lowest_cpu(input logic [CpuW-1:0] m);
      logic [TargetW-1:0] r;
      r = '0;
      if (m[0])      r = 2'd0;
      else if (m[1]) r = 2'd1;
      else if (m[2]) r = 2'd2;
      else if (m[3]) r = 2'd3;
      return r;
   endfunction

endpackage

FILE: rtl/core/irq_round_robin_distributor.sv
// Flow: an accepted vector is registered in the work register, and the merge stage
// then issues one result per cycle into the output register while rsp_tready allows;
// a result waiting with rsp_tready low stalls it. A new vector is taken only once
// the merge stage has retired every routed line of the last one.
// Reset: synchronous; control and CSR registers return to defaults, all pointers to no CPU.
// ----------------------------------------------------------------------------
// irq_round_robin_distributor
// Routes each pending, serviced interrupt line to a CPU through per-line
// round-robin lanes and a lowest-line-first merge stage.
// ----------------------------------------------------------------------------
module irq_round_robin_distributor #(
   parameter int NUM_CPUS  = 4,
   parameter int NUM_LINES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pending_vector
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] irq_number, [5:4] target_cpu, [6] forwarded
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NumLanes = (NUM_LINES < irqrr_pkg::MaxLines) ? NUM_LINES
                                                               : irqrr_pkg::MaxLines;
   localparam logic [15:0] LineEnable = 16'((17'd1 << NumLanes) - 17'd1);
   localparam logic [3:0]  CpuLimit   = (NUM_CPUS >= 4) ? 4'hF
                                                        : 4'((5'd1 << NUM_CPUS) - 5'd1);

   logic [15:0] serviced_ff;
   logic [15:0] local_ff;
   logic [3:0]  active_ff;
   logic [63:0] affinity_ff;
   logic [15:0] work_ff;
   logic [15:0] work_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  rsp_data_ff;
   logic [7:0]  rsp_data_in;
   logic        rsp_last_ff;
   logic        rsp_last_in;

   logic        csr_wr;
   logic [1:0]  csr_idx;
   logic        req_take;
   logic        issue;
   logic [3:0]  active_eff;
   logic [15:0] grant;
   logic [15:0][irqrr_pkg::TargetW-1:0] lane_target;
   irqrr_pkg::pick_type pick;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign active_eff = active_ff & CpuLimit;

   always_comb begin
      case (csr_idx)
         irqrr_pkg::RegServiced: csr_prdata = {48'd0, serviced_ff};
         irqrr_pkg::RegLocal:    csr_prdata = {48'd0, local_ff};
         irqrr_pkg::RegActive:   csr_prdata = {60'd0, active_ff};
         irqrr_pkg::RegAffinity: csr_prdata = affinity_ff;
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serviced_ff <= irqrr_pkg::ServicedReset;
         local_ff    <= irqrr_pkg::LocalReset;
         active_ff   <= irqrr_pkg::ActiveReset;
         affinity_ff <= irqrr_pkg::AffinityReset;
      end else if (csr_wr) begin
         case (csr_idx)
            irqrr_pkg::RegServiced: serviced_ff <= csr_pwdata[15:0];
            irqrr_pkg::RegLocal:    local_ff    <= csr_pwdata[15:0];
            irqrr_pkg::RegActive:   active_ff   <= csr_pwdata[3:0];
            irqrr_pkg::RegAffinity: affinity_ff <= csr_pwdata;
            default:                ;
         endcase
      end
   end

   for (genvar i = 0; i < irqrr_pkg::MaxLines; i++) begin : g_lane
      if (i < NumLanes) begin : g_on
         irqrr_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .affinity   (affinity_ff[4*i +: 4]),
            .active     (active_eff),
            .keep_local (local_ff[i]),
            .grant      (grant[i] && issue),
            .target     (lane_target[i])
         );
      end else begin : g_off
         assign lane_target[i] = '0;
      end
   end

   irqrr_merge u_merge (
      .work        (work_ff),
      .lane_target (lane_target),
      .grant       (grant),
      .pick        (pick)
   );

   assign req_tready = (work_ff == '0);
   assign req_take   = req_tvalid && req_tready;
   assign issue      = pick.hit && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      work_in      = work_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_take) begin
         work_in = req_tdata & serviced_ff & LineEnable;
      end else if (issue) begin
         work_in = work_ff & ~grant;
      end
      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, (pick.target != '0), pick.target, pick.line};
         rsp_last_in  = pick.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ff      <= work_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> work_ff == ($past(req_tdata) & $past(serviced_ff) & LineEnable))
      else $error("work vector not loaded from accepted item");

   a_issue_clears_one: assert property (@(posedge clock) disable iff (reset)
      (issue && !req_take) |=> $countones(work_ff) == $countones($past(work_ff)) - 1)
      else $error("issue did not retire exactly one line");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (issue && pick.last) |=> work_ff == '0 || $past(req_take))
      else $error("last result issued with lines remaining");
`endif

endmodule

FILE: rtl/core/irqrr_lane.sv
// ----------------------------------------------------------------------------
// irqrr_lane
// One interrupt line: holds the round-robin pointer and picks the next CPU.
// ----------------------------------------------------------------------------
module irqrr_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [irqrr_pkg::CpuW-1:0]     affinity,
   input  logic [irqrr_pkg::CpuW-1:0]     active,
   input  logic                           keep_local,
   input  logic                           grant,
   output logic [irqrr_pkg::TargetW-1:0]  target
);

   logic [irqrr_pkg::PtrW-1:0]    last_cpu_ff;
   logic [irqrr_pkg::PtrW-1:0]    last_cpu_in;
   logic [irqrr_pkg::CpuW-1:0]    aff;
   logic [irqrr_pkg::CpuW-1:0]    above;
   logic                          balance;
   logic [irqrr_pkg::TargetW-1:0] pick;

   always_comb begin
      aff     = affinity & active;
      balance = !keep_local && (aff != '0);
      if (last_cpu_ff == irqrr_pkg::NoCpu) begin
         above = aff;
      end else if (last_cpu_ff < 3'd3) begin
         above = aff & 4'(4'b1110 << last_cpu_ff[1:0]);
      end else begin
         above = '0;
      end
      pick   = (above != '0) ? irqrr_pkg::lowest_cpu(above) : irqrr_pkg::lowest_cpu(aff);
      target = balance ? pick : '0;
      last_cpu_in = (grant && balance) ? {1'b0, pick} : last_cpu_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cpu_ff <= irqrr_pkg::NoCpu;
      end else begin
         last_cpu_ff <= last_cpu_in;
      end
   end

endmodule

FILE: rtl/core/irqrr_merge.sv
// ----------------------------------------------------------------------------
// irqrr_merge
// Selects the lowest remaining line and merges its lane result.
// ----------------------------------------------------------------------------
module irqrr_merge (
   input  logic [irqrr_pkg::MaxLines-1:0]                        work,
   input  logic [irqrr_pkg::MaxLines-1:0][irqrr_pkg::TargetW-1:0] lane_target,
   output logic [irqrr_pkg::MaxLines-1:0]                        grant,
   output irqrr_pkg::pick_type                                   pick
);

   logic [irqrr_pkg::MaxLines-1:0] rest;

   always_comb begin
      grant       = work & (~work + 16'd1);
      rest        = work & ~grant;
      pick.hit    = (work != '0);
      pick.line   = '0;
      pick.target = '0;
      for (int i = 0; i < irqrr_pkg::MaxLines; i++) begin
         if (grant[i]) begin
            pick.line   = pick.line | irqrr_pkg::LineW'(i);
            pick.target = pick.target | lane_target[i];
         end
      end
      pick.last = (rest == '0);
   end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Sends pending-interrupt vectors to the round-robin distributor. A local
// copy of the routing state predicts every routing result, and each result
// the block returns is checked field by field. The masks and the affinity
// map are changed over the APB port between phases of directed, back-pressure
// and random traffic, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 500000;
   localparam int DrainCycles = 20;
   localparam int HoldCycles = 400;

   typedef struct packed {
      logic [irqrr_pkg::LineW-1:0]   irq;
      logic [irqrr_pkg::TargetW-1:0] target;
      logic                          forwarded;
      logic                          last;
   } route_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;    // [3:0] irq_number, [5:4] target_cpu, [6] forwarded, [7] zero
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // routing state mirrored from the block
   logic [15:0]                  serviced_lines;
   logic [15:0]                  local_lines;
   logic [irqrr_pkg::CpuW-1:0]   online_cpus;
   logic [63:0]                  affinity_map;
   logic [irqrr_pkg::PtrW-1:0]   rr_pointer [irqrr_pkg::MaxLines];

   route_type expected_routes [$];
   route_type next_route;

   int  error_count = 0;
   int  cycle_count = 0;
   bit  no_idle = 1'b0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;

   irq_round_robin_distributor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL irq_round_robin_distributor");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 24);
      end
   end

   task automatic report_mismatch(input string what, input int expected, input int actual);
      error_count++;
      if (error_count <= 50)
         $display("mismatch %s: expected %0d, got %0d (cycle %0d)",
                  what, expected, actual, cycle_count);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_routes.size() == 0) begin
            report_mismatch("unexpected item, tdata", -1, rsp_tdata);
         end else begin
            next_route = expected_routes.pop_front();
            if (rsp_tdata[3:0] !== next_route.irq)
               report_mismatch("irq_number", next_route.irq, rsp_tdata[3:0]);
            if (rsp_tdata[5:4] !== next_route.target)
               report_mismatch("target_cpu", next_route.target, rsp_tdata[5:4]);
            if (rsp_tdata[6] !== next_route.forwarded)
               report_mismatch("forwarded", next_route.forwarded, rsp_tdata[6]);
            if (rsp_tdata[7] !== 1'b0)
               report_mismatch("tdata padding", 0, rsp_tdata[7]);
            if (rsp_tlast !== next_route.last)
               report_mismatch("last_of_run", next_route.last, rsp_tlast);
         end
      end
   end

   function automatic logic [irqrr_pkg::TargetW-1:0] first_cpu_in(
      input logic [irqrr_pkg::CpuW-1:0] cpus);
      logic [irqrr_pkg::TargetW-1:0] pick;
      pick = '0;
      for (int c = irqrr_pkg::CpuW - 1; c >= 0; c--)
         if (cpus[c]) pick = irqrr_pkg::TargetW'(c);
      return pick;
   endfunction

   function automatic void clear_routing_state();
      serviced_lines = irqrr_pkg::ServicedReset;
      local_lines = irqrr_pkg::LocalReset;
      online_cpus = irqrr_pkg::ActiveReset;
      affinity_map = irqrr_pkg::AffinityReset;
      for (int n = 0; n < irqrr_pkg::MaxLines; n++) rr_pointer[n] = irqrr_pkg::NoCpu;
   endfunction

   // work out the routing results of one vector and advance the pointers
   function automatic void route_vector(input logic [15:0] pending);
      logic [15:0]                   work;
      logic [irqrr_pkg::CpuW-1:0]    cpus;
      logic [irqrr_pkg::CpuW-1:0]    above;
      logic [irqrr_pkg::PtrW-1:0]    prev;
      logic [irqrr_pkg::TargetW-1:0] target;
      route_type                     routes [irqrr_pkg::MaxLines];
      int                            count;
      count = 0;
      work = pending & serviced_lines;
      for (int n = 0; n < irqrr_pkg::MaxLines; n++) begin
         if (work[n]) begin
            cpus = affinity_map[4*n +: 4] & online_cpus;
            target = '0;
            if (!local_lines[n] && cpus != '0) begin
               prev = rr_pointer[n];
               if (prev == irqrr_pkg::NoCpu) above = cpus;
               else if (prev < 3) above = cpus & ~((4'd2 << prev) - 4'd1);
               else above = '0;
               target = first_cpu_in((above != '0) ? above : cpus);
               rr_pointer[n] = irqrr_pkg::PtrW'(target);
            end
            routes[count].irq = irqrr_pkg::LineW'(n);
            routes[count].target = target;
            routes[count].forwarded = (target != '0);
            routes[count].last = 1'b0;
            count++;
         end
      end
      for (int k = 0; k < count; k++) begin
         if (k == count - 1) routes[k].last = 1'b1;
         expected_routes.push_back(routes[k]);
      end
   endfunction

   task automatic send_vector(input logic [15:0] pending);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pending;
      do @(posedge clock); while (!req_tready);
      route_vector(pending);
   endtask

   // drop valid, drain all results, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_routes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         irqrr_pkg::RegServiced: serviced_lines = value[15:0];
         irqrr_pkg::RegLocal:    local_lines = value[15:0];
         irqrr_pkg::RegActive:   online_cpus = value[irqrr_pkg::CpuW-1:0];
         irqrr_pkg::RegAffinity: affinity_map = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] serviced, input logic [15:0] local_set,
                            input logic [3:0] active, input logic [63:0] affinity);
      write_reg(irqrr_pkg::RegServiced, {48'd0, serviced});
      write_reg(irqrr_pkg::RegLocal, {48'd0, local_set});
      write_reg(irqrr_pkg::RegActive, {60'd0, active});
      write_reg(irqrr_pkg::RegAffinity, affinity);
   endtask

   task automatic test_default_routing();
      send_vector(16'h0000);
      send_vector(16'h2C04);
      repeat (5) send_vector(16'hFFFF);
      send_vector(16'h0001);
      send_vector(16'h8000);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_all(16'hFFFF, 16'h0000, 4'hF, 64'hA5C3_6969_F0F1_2480);
      repeat (3) send_vector(16'hFFFF);
      wait_idle();
      write_reg(irqrr_pkg::RegActive, 64'h0);
      send_vector(16'hFFFF);
      wait_idle();
      write_reg(irqrr_pkg::RegActive, 64'h6);
      write_reg(irqrr_pkg::RegLocal, 64'hAAAA);
      repeat (2) send_vector(16'hFFFF);
      wait_idle();
      write_reg(irqrr_pkg::RegAffinity, 64'h0);
      send_vector(16'hFFFF);
      wait_idle();
      write_all(16'h0000, 16'hFFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_vector(16'hFFFF);
      wait_idle();
      write_reg(irqrr_pkg::RegServiced, 64'hFFFF);
      send_vector(16'h5A5A);
      wait_idle();
      write_reg(irqrr_pkg::RegLocal, 64'h0);
      send_vector(16'hA5A5);
      send_vector(16'h8001);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      write_all(16'hFFFF, 16'h0000, 4'hF, {$urandom, $urandom});
      hold_requests++;
      repeat (6) send_vector(16'hFFFF);
      wait_idle();
   endtask

   function automatic logic [15:0] random_vector();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return 16'h0000;
      if (pick < 16) return 16'hFFFF;
      if (pick < 35) return 16'h1 << $urandom_range(15);
      if (pick < 50) return 16'($urandom & $urandom);
      return 16'($urandom);
   endfunction

   task automatic test_random_traffic();
      logic [15:0] serviced;
      logic [15:0] local_set;
      logic [63:0] affinity;
      for (int phase = 0; phase < 7; phase++) begin
         serviced = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
         local_set = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom & $urandom);
         affinity = ($urandom_range(2) == 0) ? {$urandom & $urandom, $urandom & $urandom}
                                             : {$urandom, $urandom};
         write_all(serviced, local_set, 4'($urandom_range(15)), affinity);
         no_idle = (phase == 2);
         repeat (62) send_vector(random_vector());
         wait_idle();
         no_idle = 1'b0;
      end
   endtask

   initial begin
      clear_routing_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_routing();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("PASS irq_round_robin_distributor");
      end else begin
         $display("FAIL irq_round_robin_distributor");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/irqrr_pkg.sv
rtl/core/irqrr_lane.sv
rtl/core/irqrr_merge.sv
rtl/core/irq_round_robin_distributor.sv
test/tb_top.sv
